### hw/rtl/btpc_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants for the barometric compensation block
package btpc_pkg;

    localparam int RAW_T_W = 16;
    localparam int RAW_P_W = 19;
    localparam int TEMP_W  = 16;
    localparam int PRESS_W = 18;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 32;

    // temperature divider: magnitude of mc*2048 over magnitude of x1+md
    localparam int T_NUM_W = 27;
    localparam int T_DEN_W = 18;
    localparam int TDIV_N  = T_NUM_W;

    // pressure divider: 64-bit numerator over b4
    localparam int P_NUM_W = 64;
    localparam int P_DEN_W = 49;
    localparam int PDIV_N  = P_NUM_W;

    localparam logic [2:0] REG_AC1_AC2 = 3'd0;
    localparam logic [2:0] REG_AC3_AC4 = 3'd1;
    localparam logic [2:0] REG_AC5_AC6 = 3'd2;
    localparam logic [2:0] REG_B1_B2   = 3'd3;
    localparam logic [2:0] REG_MC_MD   = 3'd4;
    localparam logic [2:0] REG_OSS     = 3'd5;

    localparam logic signed [27:0] B6_OFS   = 28'sd4000;
    localparam logic signed [43:0] B4_OFS   = 44'sd32768;
    localparam logic [15:0]        K_FIFTY  = 16'd50000;
    localparam logic [11:0]        K_Y1     = 12'd3038;
    localparam logic [12:0]        K_Y2     = 13'd7357;
    localparam logic [63:0]        K_Y3     = 64'd3791;
    localparam logic [PRESS_W-1:0] PRESS_MAX = 18'd262143;

    typedef struct packed {
        logic [31:0] ac1_ac2;
        logic [31:0] ac3_ac4;
        logic [31:0] ac5_ac6;
        logic [31:0] b1_b2;
        logic [31:0] mc_md;
        logic [1:0]  oss;
    } btpc_cal_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic [PRESS_W-1:0]       pressure;
        logic                     fault;
    } btpc_res_t;

endpackage

### hw/rtl/btpc_if.sv
`timescale 1ns / 1ps
// item channels: raw sample in, compensated result out
interface btpc_in_if import btpc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RAW_T_W-1:0] raw_temperature;
    logic [RAW_P_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface btpc_out_if import btpc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic [PRESS_W-1:0]       pressure;
    logic                     fault;

    modport source (output valid, output temperature, output pressure, output fault,
                    input ready);
    modport sink (input valid, input temperature, input pressure, input fault,
                  output ready);
endinterface

### hw/rtl/btpc_cfg.sv
`timescale 1ns / 1ps
// apb register file holding the calibration words and oversampling setting
module btpc_cfg import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output btpc_cal_t         cal
);

    btpc_cal_t  cal_reg;
    btpc_cal_t  cal_next;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_comb
    begin
        cal_next = cal_reg;
        if (wr)
        begin
            case (idx)
                REG_AC1_AC2: cal_next.ac1_ac2 = pwdata;
                REG_AC3_AC4: cal_next.ac3_ac4 = pwdata;
                REG_AC5_AC6: cal_next.ac5_ac6 = pwdata;
                REG_B1_B2:   cal_next.b1_b2   = pwdata;
                REG_MC_MD:   cal_next.mc_md   = pwdata;
                REG_OSS:     cal_next.oss     = pwdata[1:0];
                default:     cal_next = cal_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_AC1_AC2: prdata = cal_reg.ac1_ac2;
            REG_AC3_AC4: prdata = cal_reg.ac3_ac4;
            REG_AC5_AC6: prdata = cal_reg.ac5_ac6;
            REG_B1_B2:   prdata = cal_reg.b1_b2;
            REG_MC_MD:   prdata = cal_reg.mc_md;
            REG_OSS:     prdata = {30'd0, cal_reg.oss};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

endmodule

### hw/rtl/btpc_tdiv.sv
`timescale 1ns / 1ps
// pipelined restoring divider for the temperature term, one quotient bit per stage
module btpc_tdiv import btpc_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic [T_NUM_W-1:0] num,
    input  logic [T_DEN_W-1:0] den,
    output logic [T_NUM_W-1:0] quo
);

    logic [T_DEN_W-1:0] rem_reg  [TDIV_N];
    logic [T_DEN_W-1:0] rem_next [TDIV_N];
    logic [T_NUM_W-1:0] dvd_reg  [TDIV_N];
    logic [T_NUM_W-1:0] dvd_next [TDIV_N];
    logic [T_DEN_W-1:0] dsr_reg  [TDIV_N];
    logic [T_DEN_W-1:0] dsr_next [TDIV_N];

    genvar k;
    for (k = 0; k < TDIV_N; k++)
    begin : g_stage
        logic [T_DEN_W-1:0] r_in;
        logic [T_DEN_W-1:0] dn_in;
        logic [T_NUM_W-1:0] d_in;
        logic [T_DEN_W:0]   part;
        logic [T_DEN_W:0]   diff;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign r_in  = '0;
            assign d_in  = num;
            assign dn_in = den;
        end
        else
        begin : g_rest
            assign r_in  = rem_reg[k-1];
            assign d_in  = dvd_reg[k-1];
            assign dn_in = dsr_reg[k-1];
        end

        // dividend bits leave at the top, quotient bits come in at the bottom
        assign part        = {r_in, d_in[T_NUM_W-1]};
        assign diff        = part - {1'b0, dn_in};
        assign ge          = part >= {1'b0, dn_in};
        assign rem_next[k] = ge ? diff[T_DEN_W-1:0] : part[T_DEN_W-1:0];
        assign dvd_next[k] = {d_in[T_NUM_W-2:0], ge};
        assign dsr_next[k] = dn_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < TDIV_N; i++)
            begin
                rem_reg[i] <= rem_next[i];
                dvd_reg[i] <= dvd_next[i];
                dsr_reg[i] <= dsr_next[i];
            end
        end
    end

    assign quo = dvd_reg[TDIV_N-1];

endmodule

### hw/rtl/btpc_pdiv.sv
`timescale 1ns / 1ps
// pipelined restoring divider for the pressure term, one quotient bit per stage
module btpc_pdiv import btpc_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic [P_NUM_W-1:0] num,
    input  logic [P_DEN_W-1:0] den,
    output logic [P_NUM_W-1:0] quo
);

    logic [P_DEN_W-1:0] rem_reg  [PDIV_N];
    logic [P_DEN_W-1:0] rem_next [PDIV_N];
    logic [P_NUM_W-1:0] dvd_reg  [PDIV_N];
    logic [P_NUM_W-1:0] dvd_next [PDIV_N];
    logic [P_DEN_W-1:0] dsr_reg  [PDIV_N];
    logic [P_DEN_W-1:0] dsr_next [PDIV_N];

    genvar k;
    for (k = 0; k < PDIV_N; k++)
    begin : g_stage
        logic [P_DEN_W-1:0] r_in;
        logic [P_DEN_W-1:0] dn_in;
        logic [P_NUM_W-1:0] d_in;
        logic [P_DEN_W:0]   part;
        logic [P_DEN_W:0]   diff;
        logic               ge;

        if (k == 0)
        begin : g_first
            assign r_in  = '0;
            assign d_in  = num;
            assign dn_in = den;
        end
        else
        begin : g_rest
            assign r_in  = rem_reg[k-1];
            assign d_in  = dvd_reg[k-1];
            assign dn_in = dsr_reg[k-1];
        end

        assign part        = {r_in, d_in[P_NUM_W-1]};
        assign diff        = part - {1'b0, dn_in};
        assign ge          = part >= {1'b0, dn_in};
        assign rem_next[k] = ge ? diff[P_DEN_W-1:0] : part[P_DEN_W-1:0];
        assign dvd_next[k] = {d_in[P_NUM_W-2:0], ge};
        assign dsr_next[k] = dn_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < PDIV_N; i++)
            begin
                rem_reg[i] <= rem_next[i];
                dvd_reg[i] <= dvd_next[i];
                dsr_reg[i] <= dsr_next[i];
            end
        end
    end

    assign quo = dvd_reg[PDIV_N-1];

endmodule

### hw/rtl/baro_temp_pressure_compensation.sv
`timescale 1ns / 1ps
// barometric temperature and pressure compensation, top level pipeline
//
// usage:
//   sample carries one raw temperature and one raw pressure reading per item;
//   result returns the temperature in 0.1 degC, the pressure in Pa and a fault
//   flag (a zero divisor). both are valid/ready channels.
//   the user must write calibration words and oversampling over the apb port
//   only while no item is in flight (not enforced); pready is always high.
// timing:
//   one item per cycle sustained while result.ready stays high; the depth is
//   set by the two bit-per-stage dividers (27 stages for the temperature
//   term, 64 for the pressure term) plus 19 arithmetic stages.
// reset:
//   rst_n clears every valid bit and the calibration registers to zero, not
//   the datapath; the pipeline starts empty and sample.ready is high.
// stalls:
//   while result.ready is low the output register holds its item and a skid
//   register takes the next one; only when both are full does the whole
//   pipeline freeze and sample.ready fall. nothing is dropped or repeated.
module baro_temp_pressure_compensation import btpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    btpc_in_if.sink           sample,
    btpc_out_if.source        result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int I_X1   = 0;
    localparam int I_S2   = 1;
    localparam int I_B5   = I_S2 + 1 + TDIV_N;
    localparam int I_T    = I_B5 + 1;
    localparam int I_SQ   = I_T + 1;
    localparam int I_X1A  = I_SQ + 1;
    localparam int I_X3   = I_X1A + 1;
    localparam int I_V    = I_X3 + 1;
    localparam int I_B3   = I_V + 1;
    localparam int I_D    = I_B3 + 1;
    localparam int I_B7P  = I_D + 1;
    localparam int I_B7   = I_B7P + 1;
    localparam int I_NUM  = I_B7 + 1;
    localparam int I_P    = I_NUM + 1 + PDIV_N;
    localparam int I_PP   = I_P + 1;
    localparam int I_Y1SQ = I_PP + 1;
    localparam int I_Y1P  = I_Y1SQ + 1;
    localparam int I_Y1   = I_Y1P + 1;
    localparam int I_S    = I_Y1 + 1;
    localparam int NSTAGE = I_S + 1;

    typedef struct packed {
        logic [RAW_P_W-1:0]       up;
        logic signed [17:0]       x1;
        logic                     qneg;
        logic                     flt_t;
        logic signed [TEMP_W-1:0] temp;
        logic                     flt_p;
        logic                     b7_low;
    } side_t;

    btpc_cal_t cal;

    logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0]        ac4, ac5, ac6;

    logic              adv;
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    side_t             side_reg  [NSTAGE];
    side_t             side_next [NSTAGE];

    // stage math
    logic signed [16:0] d17;
    logic signed [33:0] x1p;
    logic signed [17:0] x1_c;
    logic [18:0]        den19;
    logic [18:0]        dneg;
    logic [26:0]        num27;
    logic [26:0]        num_neg;
    logic               qneg_c;
    logic               flt_t_c;
    logic [T_NUM_W-1:0] tnum_reg, tnum_next;
    logic [T_DEN_W-1:0] tden_reg, tden_next;
    logic [T_NUM_W-1:0] tq;
    logic [27:0]        q28;
    logic [27:0]        x2_c;
    logic signed [27:0] b5_reg, b5_next;
    logic signed [28:0] bsum;
    logic signed [24:0] t_wide;
    logic signed [TEMP_W-1:0] temp_c;
    logic signed [27:0] b6_reg, b6_next;
    logic signed [55:0] sqf;
    logic signed [43:0] p2a, p3c;
    logic signed [43:0] sq_reg, sq_next;
    logic signed [32:0] x2a_reg, x2a_next, x2a_b_reg;
    logic signed [30:0] x1c_reg, x1c_next, x1c_b_reg;
    logic signed [59:0] pb2, pb1;
    logic signed [48:0] x1a_reg, x1a_next;
    logic signed [43:0] x2c_reg, x2c_next;
    logic signed [49:0] x3a_reg, x3a_next;
    logic signed [44:0] x3cs;
    logic signed [42:0] x3c_reg, x3c_next;
    logic signed [50:0] vsum;
    logic signed [53:0] vsh;
    logic signed [54:0] v_reg, v_next;
    logic signed [43:0] x3cp_reg, x3cp_next;
    logic signed [54:0] vr;
    logic signed [52:0] b3_reg, b3_next;
    logic signed [60:0] b4p_reg, b4p_next;
    logic [63:0]        b4e;
    logic [63:0]        d_reg, d_next;
    logic [P_DEN_W-1:0] b4_reg, b4_next, b4_b_reg, b4_c_reg;
    logic               flt_p_c;
    logic [15:0]        kmul;
    logic [47:0]        lo_reg, lo_next;
    logic [47:0]        hiprod;
    logic [31:0]        hi_reg, hi_next;
    logic [63:0]        b7_reg, b7_next;
    logic               small_c;
    logic [P_NUM_W-1:0] pnum_reg, pnum_next;
    logic [P_DEN_W-1:0] pden_reg, pden_next;
    logic [P_NUM_W-1:0] pq;
    logic [63:0]        p_reg, p_next;
    logic [63:0]        y;
    logic [63:0]        ll_reg, ll_next;
    logic [63:0]        lhf;
    logic [31:0]        lh_reg, lh_next;
    logic [44:0]        pml_reg, pml_next;
    logic [44:0]        pmhf;
    logic [31:0]        pmh_reg, pmh_next;
    logic [63:0]        p_pp_reg;
    logic [63:0]        pm, pmn;
    logic [63:0]        y1sq_reg, y1sq_next;
    logic [63:0]        y2_reg, y2_next, y2_b_reg, y2_c_reg;
    logic [63:0]        p_sq_reg;
    logic [43:0]        am_reg, am_next;
    logic [43:0]        bmf;
    logic [31:0]        bm_reg, bm_next;
    logic [63:0]        p_y1p_reg;
    logic [63:0]        y1m;
    logic [63:0]        y1_reg, y1_next;
    logic [63:0]        p_y1_reg;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        p_s_reg;
    logic [63:0]        pr;

    // output register and skid
    btpc_res_t fin_c;
    btpc_res_t out_reg, out_next;
    btpc_res_t skid_reg, skid_next;
    logic      out_vld_reg, out_vld_next;
    logic      skid_vld_reg, skid_vld_next;

    btpc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    assign ac1 = cal.ac1_ac2[31:16];
    assign ac2 = cal.ac1_ac2[15:0];
    assign ac3 = cal.ac3_ac4[31:16];
    assign ac4 = cal.ac3_ac4[15:0];
    assign ac5 = cal.ac5_ac6[31:16];
    assign ac6 = cal.ac5_ac6[15:0];
    assign b1  = cal.b1_b2[31:16];
    assign b2  = cal.b1_b2[15:0];
    assign mc  = cal.mc_md[31:16];
    assign md  = cal.mc_md[15:0];

    // the whole pipeline moves together; it stops only when the skid is full
    assign adv          = !skid_vld_reg;
    assign sample.ready = adv;

    // ---------------- temperature path ----------------

    assign d17  = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, ac6});
    assign x1p  = d17 * $signed({1'b0, ac5});
    assign x1_c = x1p[32:15];

    always_comb
    begin
        den19     = {side_reg[I_X1].x1[17], side_reg[I_X1].x1} + {{3{md[15]}}, md};
        dneg      = -den19;
        num27     = {mc, 11'd0};
        num_neg   = -num27;
        qneg_c    = num27[26] ^ den19[18];
        flt_t_c   = (den19 == '0);
        tnum_next = num27[26] ? num_neg : num27;
        tden_next = den19[18] ? dneg[T_DEN_W-1:0] : den19[T_DEN_W-1:0];
    end

    btpc_tdiv u_tdiv
    (
        .clk (clk),
        .adv (adv),
        .num (tnum_reg),
        .den (tden_reg),
        .quo (tq)
    );

    always_comb
    begin
        q28     = {1'b0, tq};
        x2_c    = side_reg[I_B5-1].qneg ? -q28 : q28;
        b5_next = {{10{side_reg[I_B5-1].x1[17]}}, side_reg[I_B5-1].x1} + x2_c;

        bsum    = b5_reg + 29'sd8;
        t_wide  = bsum[28:4];
        if (t_wide > 25'sd32767)
        begin
            temp_c = 16'sh7fff;
        end
        else if (t_wide < -25'sd32768)
        begin
            temp_c = 16'sh8000;
        end
        else
        begin
            temp_c = t_wide[15:0];
        end
        b6_next = b5_reg - B6_OFS;
    end

    // ---------------- b3 and b4 terms ----------------

    always_comb
    begin
        sqf       = b6_reg * b6_reg;
        sq_next   = sqf[55:12];
        p2a       = ac2 * b6_reg;
        x2a_next  = p2a[43:11];
        p3c       = ac3 * b6_reg;
        x1c_next  = p3c[43:13];

        pb2       = b2 * sq_reg;
        x1a_next  = pb2[59:11];
        pb1       = b1 * sq_reg;
        x2c_next  = pb1[59:16];

        x3a_next  = x1a_reg + x2a_b_reg;
        x3cs      = x1c_b_reg + x2c_reg + 45'sd2;
        x3c_next  = x3cs[44:2];

        vsum      = $signed({ac1, 2'b00}) + x3a_reg;
        vsh       = vsum <<< cal.oss;
        v_next    = vsh + 55'sd2;
        x3cp_next = x3c_reg + B4_OFS;

        // divide by four rounding toward zero
        vr        = v_reg + (v_reg[54] ? 55'sd3 : 55'sd0);
        b3_next   = vr[54:2];
        b4p_next  = $signed({1'b0, ac4}) * x3cp_reg;

        b4e       = {{3{b4p_reg[60]}}, b4p_reg};
        b4_next   = b4e[63:15];
        flt_p_c   = (b4_next == '0);
        d_next    = {45'd0, side_reg[I_D-1].up} - {{11{b3_reg[52]}}, b3_reg};
    end

    // ---------------- b7 and division setup ----------------

    always_comb
    begin
        kmul      = K_FIFTY >> cal.oss;
        lo_next   = d_reg[31:0] * kmul;
        hiprod    = d_reg[63:32] * kmul;
        hi_next   = hiprod[31:0];
        b7_next   = {16'd0, lo_reg} + {hi_reg, 32'd0};
        small_c   = (b7_reg[63:31] == '0);
        pnum_next = small_c ? {b7_reg[62:0], 1'b0} : b7_reg;
        pden_next = b4_c_reg;
    end

    btpc_pdiv u_pdiv
    (
        .clk (clk),
        .adv (adv),
        .num (pnum_reg),
        .den (pden_reg),
        .quo (pq)
    );

    // ---------------- final pressure correction ----------------

    always_comb
    begin
        p_next    = side_reg[I_P-1].b7_low ? pq : {pq[62:0], 1'b0};

        y         = {{8{p_reg[63]}}, p_reg[63:8]};
        ll_next   = y[31:0] * y[31:0];
        lhf       = y[31:0] * y[63:32];
        lh_next   = lhf[31:0];
        pml_next  = p_reg[31:0] * K_Y2;
        pmhf      = p_reg[63:32] * K_Y2;
        pmh_next  = pmhf[31:0];

        // square modulo 2^64: low product plus twice the cross term
        y1sq_next = ll_reg + {lh_reg[30:0], 33'd0};
        pm        = {19'd0, pml_reg} + {pmh_reg, 32'd0};
        pmn       = -pm;
        y2_next   = {{16{pmn[63]}}, pmn[63:16]};

        am_next   = y1sq_reg[31:0] * K_Y1;
        bmf       = y1sq_reg[63:32] * K_Y1;
        bm_next   = bmf[31:0];

        y1m       = {20'd0, am_reg} + {bm_reg, 32'd0};
        y1_next   = {{16{y1m[63]}}, y1m[63:16]};

        s_next    = y1_reg + y2_c_reg + K_Y3;

        pr        = p_s_reg + {{4{s_reg[63]}}, s_reg[63:4]};

        fin_c.temperature = side_reg[I_S].temp;
        fin_c.fault       = 1'b0;
        if (pr[63])
        begin
            fin_c.pressure = '0;
        end
        else if (pr[62:PRESS_W] != '0)
        begin
            fin_c.pressure = PRESS_MAX;
        end
        else
        begin
            fin_c.pressure = pr[PRESS_W-1:0];
        end
        if (side_reg[I_S].flt_t)
        begin
            fin_c.temperature = '0;
            fin_c.pressure    = '0;
            fin_c.fault       = 1'b1;
        end
        else if (side_reg[I_S].flt_p)
        begin
            fin_c.pressure = '0;
            fin_c.fault    = 1'b1;
        end
    end

    // ---------------- side data and valid bits ----------------

    always_comb
    begin
        vld_next     = {vld_reg[NSTAGE-2:0], sample.valid};
        side_next[0] = '0;
        side_next[0].up = sample.raw_pressure;
        side_next[0].x1 = x1_c;
        for (int i = 1; i < NSTAGE; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[I_S2].qneg  = qneg_c;
        side_next[I_S2].flt_t = flt_t_c;
        side_next[I_T].temp   = temp_c;
        side_next[I_D].flt_p  = flt_p_c;
        side_next[I_NUM].b7_low = small_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                side_reg[i] <= side_next[i];
            end
            tnum_reg  <= tnum_next;
            tden_reg  <= tden_next;
            b5_reg    <= b5_next;
            b6_reg    <= b6_next;
            sq_reg    <= sq_next;
            x2a_reg   <= x2a_next;
            x1c_reg   <= x1c_next;
            x1a_reg   <= x1a_next;
            x2c_reg   <= x2c_next;
            x2a_b_reg <= x2a_reg;
            x1c_b_reg <= x1c_reg;
            x3a_reg   <= x3a_next;
            x3c_reg   <= x3c_next;
            v_reg     <= v_next;
            x3cp_reg  <= x3cp_next;
            b3_reg    <= b3_next;
            b4p_reg   <= b4p_next;
            d_reg     <= d_next;
            b4_reg    <= b4_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            b4_b_reg  <= b4_reg;
            b7_reg    <= b7_next;
            b4_c_reg  <= b4_b_reg;
            pnum_reg  <= pnum_next;
            pden_reg  <= pden_next;
            p_reg     <= p_next;
            ll_reg    <= ll_next;
            lh_reg    <= lh_next;
            pml_reg   <= pml_next;
            pmh_reg   <= pmh_next;
            p_pp_reg  <= p_reg;
            y1sq_reg  <= y1sq_next;
            y2_reg    <= y2_next;
            p_sq_reg  <= p_pp_reg;
            am_reg    <= am_next;
            bm_reg    <= bm_next;
            y2_b_reg  <= y2_reg;
            p_y1p_reg <= p_sq_reg;
            y1_reg    <= y1_next;
            y2_c_reg  <= y2_b_reg;
            p_y1_reg  <= p_y1p_reg;
            s_reg     <= s_next;
            p_s_reg   <= p_y1_reg;
        end
    end

    // ---------------- output register with skid ----------------

    always_comb
    begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (!out_vld_reg || result.ready)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_next     = fin_c;
                out_vld_next = vld_reg[NSTAGE-1];
            end
        end
        else if (vld_reg[NSTAGE-1] && adv)
        begin
            skid_next     = fin_c;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid       = out_vld_reg;
    assign result.temperature = out_reg.temperature;
    assign result.pressure    = out_reg.pressure;
    assign result.fault       = out_reg.fault;

    // ---------------- checks ----------------

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while the output register is empty");

    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> vld_reg[0])
        else $error("accepted item did not enter the first stage");

    a_fault_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.fault) |-> (result.pressure == '0))
        else $error("faulted result carries a non-zero pressure");

endmodule
